### rtl/core/ax25_frame_bit_serializer_defines.svh
// assertion macros for the ax25 frame bit serializer checker
// no dependencies; included by files that carry concurrent assertions
`ifndef AX25_FRAME_BIT_SERIALIZER_DEFINES_SVH
`define AX25_FRAME_BIT_SERIALIZER_DEFINES_SVH

// clocked assertion, switched off while reset is asserted
`define AX25FS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define AX25FS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/ax25fs_pkg.sv
// shared types and constants for the ax25 frame bit serializer
// no dependencies; imported by the top level, the store and the tx core
`default_nettype none

package ax25fs_pkg;

  // item commands
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_START_FLAGS = 2'd0,
    REG_END_FLAGS   = 2'd1,
    REG_BODY_LEN    = 2'd2,
    REG_FCS         = 2'd3
  } reg_e;

  // frame sequencing phases
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_OPEN   = 3'd1,
    PH_BODY   = 3'd2,
    PH_FCS_LO = 3'd3,
    PH_FCS_HI = 3'd4,
    PH_CLOSE  = 3'd5
  } phase_e;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [2:0] STUFF_RUN = 3'd5;
  localparam logic [2:0] ONES_MAX  = 3'd7;
  localparam logic [3:0] BYTE_BITS = 4'd8;

  localparam logic [7:0]  START_FLAGS_RST = 8'd1;
  localparam logic [7:0]  END_FLAGS_RST   = 8'd0;
  localparam logic [6:0]  BODY_LEN_RST    = 7'd64;
  localparam logic [15:0] FCS_RST         = 16'd0;

  // configuration register set
  typedef struct packed {
    logic [7:0]  start_flag_count;
    logic [7:0]  end_flag_count;
    logic [6:0]  body_length;
    logic [15:0] frame_check;
  } cfg_t;

  // one input item
  typedef struct packed {
    logic [1:0] command;
    logic [5:0] byte_index;
    logic [7:0] byte_value;
  } item_t;

  // line status after an item
  typedef struct packed {
    logic line_level;
    logic frame_done;
  } status_t;

endpackage

`default_nettype wire

### rtl/core/ax25_frame_bit_serializer.sv
// AX.25 / HDLC frame bit serializer top level
// depends on ax25fs_pkg, ax25fs_store and ax25fs_tx_core
//
// Usage: each item on the input channel carries a command: load writes one
// body byte into the frame store, start re-arms the frame, tick shifts out one
// NRZI line bit (opening flags, body, FCS low then high, closing flags).
// Every item gives exactly one result item with the line level and the done
// flag. The configuration channel writes flag counts, body length and FCS;
// it is always ready; the user must write it only while the block is idle,
// which the block itself does not enforce. A result passes the input register,
// then the result register; a full result slot holds its item in the first.
// Throughput: one item per cycle while results are taken, set by the
// combinational state update and the read-ahead port of the frame store.
// A stalled receiver holds the result register; the input register then fills
// and in_ready_o drops until the result is taken.
// Reset clears sequencing state, the line level and the configuration to
// their defaults at once; the frame store is not cleared and every entry
// must be loaded before a frame reads it.
`default_nettype none

module ax25_frame_bit_serializer
  import ax25fs_pkg::*;
#(
  parameter int BODY_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [5:0]  byte_index_i,
  input  wire logic [7:0]  byte_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             line_bit_o,
  output logic             frame_done_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int AW = (BODY_DEPTH > 1) ? $clog2(BODY_DEPTH) : 1;

  item_t         item_q;
  logic          item_valid_q;
  status_t       result_q;
  logic          out_valid_q;
  cfg_t          cfg_q;
  logic          adv;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  status_t       status;

  // handshake: process the held item whenever the result slot frees
  assign adv         = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !item_valid_q || adv;
  assign cfg_ready_o = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.command    <= command_i;
      item_q.byte_index <= byte_index_i;
      item_q.byte_value <= byte_value_i;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_flag_count <= START_FLAGS_RST;
      cfg_q.end_flag_count   <= END_FLAGS_RST;
      cfg_q.body_length      <= BODY_LEN_RST;
      cfg_q.frame_check      <= FCS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_START_FLAGS: cfg_q.start_flag_count <= cfg_data_i[7:0];
        REG_END_FLAGS:   cfg_q.end_flag_count   <= cfg_data_i[7:0];
        REG_BODY_LEN:    cfg_q.body_length      <= cfg_data_i[6:0];
        REG_FCS:         cfg_q.frame_check      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // frame body store
  ax25fs_store #(
    .BODY_DEPTH (BODY_DEPTH)
  ) u_store (
    .clk_i        (clk_i),
    .wr_en_i      (adv && (item_q.command == CMD_LOAD)),
    .byte_index_i (item_q.byte_index),
    .wr_data_i    (item_q.byte_value),
    .rd_addr_i    (rd_addr),
    .rd_data_o    (rd_data)
  );

  // sequencer and line coder
  ax25fs_tx_core #(
    .BODY_DEPTH (BODY_DEPTH)
  ) u_tx_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .item_i    (item_q),
    .cfg_i     (cfg_q),
    .rd_data_i (rd_data),
    .rd_addr_o (rd_addr),
    .status_o  (status)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      result_q <= status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_bit_o   = result_q.line_level;
  assign frame_done_o = result_q.frame_done;

endmodule

`default_nettype wire

### rtl/core/ax25fs_store.sv
// frame body store: one write port, one registered read port with write bypass
// depends on ax25fs_pkg
`default_nettype none

module ax25fs_store
  import ax25fs_pkg::*;
#(
  parameter int BODY_DEPTH = 64,
  localparam int AW = (BODY_DEPTH > 1) ? $clog2(BODY_DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [5:0]    byte_index_i,
  input  wire logic [7:0]    wr_data_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [7:0]    rd_data_o
);

  logic [7:0]    mem [BODY_DEPTH];
  logic [AW-1:0] idx_map [64];
  logic [AW-1:0] wr_addr;

  // store position of every load index, wrapped by the depth
  for (genvar gi = 0; gi < 64; gi++) begin : g_idx
    assign idx_map[gi] = AW'(gi % BODY_DEPTH);
  end

  assign wr_addr = idx_map[byte_index_i];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr] <= wr_data_i;
    end
  end

  // read port, a load to the same entry is forwarded
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr == rd_addr_i)) begin
      rd_data_o <= wr_data_i;
    end else begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/ax25fs_tx_core.sv
// frame sequencer, bit stuffing and nrzi line coding for one item per cycle while adv_i is high
// depends on ax25fs_pkg; body bytes come from ax25fs_store
`default_nettype none

module ax25fs_tx_core
  import ax25fs_pkg::*;
#(
  parameter int BODY_DEPTH = 64,
  localparam int AW = (BODY_DEPTH > 1) ? $clog2(BODY_DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire item_t         item_i,
  input  wire cfg_t          cfg_i,
  input  wire logic [7:0]    rd_data_i,
  output logic      [AW-1:0] rd_addr_o,
  output status_t            status_o
);

  localparam logic [AW-1:0] PTR_LAST = AW'(BODY_DEPTH - 1);

  phase_e        phase_q, phase_d;
  logic [7:0]    position_q, position_d;
  logic [7:0]    shift_q, shift_d;
  logic [3:0]    bits_q, bits_d;
  logic [2:0]    ones_q, ones_d;
  logic          stuff_q, stuff_d;
  logic          level_q, level_d;
  logic          done_q, done_d;
  logic [AW-1:0] ptr_q, ptr_d;

  // next state for one item
  always_comb begin
    logic [7:0] byte_v;
    logic [8:0] pos_inc;
    logic [3:0] bits_v;
    logic [2:0] ones_v;

    phase_d    = phase_q;
    position_d = position_q;
    shift_d    = shift_q;
    bits_d     = bits_q;
    ones_d     = ones_q;
    stuff_d    = stuff_q;
    level_d    = level_q;
    done_d     = done_q;
    ptr_d      = ptr_q;
    byte_v     = shift_q;
    pos_inc    = {1'b0, position_q} + 9'd1;
    bits_v     = bits_q;
    ones_v     = ones_q;

    if (adv_i) begin
      case (item_i.command)
        CMD_START: begin
          phase_d = PH_START;
          done_d  = 1'b0;
          bits_d  = BYTE_BITS;
          ones_d  = '0;
          stuff_d = 1'b0;
        end
        CMD_TICK: begin
          // byte fetch once the previous byte is out
          if (bits_q >= BYTE_BITS) begin
            bits_v = '0;
            case (phase_q)
              PH_START, PH_OPEN: begin
                byte_v = FLAG_BYTE;
                if (phase_q == PH_START) begin
                  stuff_d = 1'b0;
                  pos_inc = 9'd1;
                end
                if (pos_inc >= {1'b0, cfg_i.start_flag_count}) begin
                  phase_d    = PH_BODY;
                  position_d = '0;
                  ptr_d      = '0;
                end else begin
                  phase_d    = PH_OPEN;
                  position_d = pos_inc[7:0];
                end
              end
              PH_BODY: begin
                stuff_d = 1'b1;
                byte_v  = rd_data_i;
                ptr_d   = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
                if (pos_inc >= {2'b00, cfg_i.body_length}) begin
                  phase_d    = PH_FCS_LO;
                  position_d = '0;
                end else begin
                  position_d = pos_inc[7:0];
                end
              end
              PH_FCS_LO: begin
                byte_v  = cfg_i.frame_check[7:0];
                phase_d = PH_FCS_HI;
              end
              PH_FCS_HI: begin
                byte_v  = cfg_i.frame_check[15:8];
                phase_d = PH_CLOSE;
              end
              PH_CLOSE: begin
                stuff_d = 1'b0;
                byte_v  = FLAG_BYTE;
                if (position_q >= cfg_i.end_flag_count) begin
                  done_d     = 1'b1;
                  position_d = '0;
                end else begin
                  position_d = pos_inc[7:0];
                end
              end
              default: begin
                byte_v = FLAG_BYTE;
              end
            endcase
          end

          // send the low bit, stuff a zero after five ones in the body and FCS
          if (byte_v[0]) begin
            ones_v = (ones_q < ONES_MAX) ? ones_q + 3'd1 : ones_q;
            if (stuff_d && (ones_v >= STUFF_RUN)) begin
              shift_d = {byte_v[7:1], 1'b0};
              bits_d  = bits_v;
              ones_d  = '0;
            end else begin
              shift_d = {1'b0, byte_v[7:1]};
              bits_d  = bits_v + 4'd1;
              ones_d  = ones_v;
            end
          end else begin
            shift_d = {1'b0, byte_v[7:1]};
            bits_d  = bits_v + 4'd1;
            ones_d  = '0;
            level_d = ~level_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      position_q <= '0;
      shift_q    <= '0;
      bits_q     <= BYTE_BITS;
      ones_q     <= '0;
      stuff_q    <= 1'b0;
      level_q    <= 1'b0;
      done_q     <= 1'b0;
      ptr_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      position_q <= position_d;
      shift_q    <= shift_d;
      bits_q     <= bits_d;
      ones_q     <= ones_d;
      stuff_q    <= stuff_d;
      level_q    <= level_d;
      done_q     <= done_d;
      ptr_q      <= ptr_d;
    end
  end

  // read ahead the body byte for the next fetch
  assign rd_addr_o           = ptr_d;
  assign status_o.line_level = level_d;
  assign status_o.frame_done = done_d;

endmodule

`default_nettype wire

### rtl/core/ax25fs_checker.sv
// port-level checker for the ax25 frame bit serializer, bound to the top level
// depends on ax25_frame_bit_serializer_defines.svh
`default_nettype none

`include "ax25_frame_bit_serializer_defines.svh"

module ax25fs_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic line_bit_o,
  input wire logic frame_done_o
);

  // a stalled result stays offered and unchanged
  `AX25FS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(line_bit_o) && $stable(frame_done_o), "stalled result changed")

  // no result is offered while reset is held
  `AX25FS_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !out_valid_o, "result offered in reset")

  // an empty result slot never blocks the input side
  `AX25FS_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o, "input stalled with empty output")

  // a fresh result comes from an accepted item that has passed the input register
  `AX25FS_ASSERT(a_rise_after_accept, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2), "result without accepted item")

endmodule

bind ax25_frame_bit_serializer ax25fs_checker u_checker (.*);

`default_nettype wire
